@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the ASCII integer parser.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define AIP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define AIP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ src/aip_pkg.sv @@
// Shared types and character constants of the ASCII integer parser.
// Depends on nothing; used by aip_class and ascii_integer_parser_core.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

  // Character codes that the parser recognises.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UC_A  = 8'd65;
  localparam logic [7:0] CH_UC_F  = 8'd70;
  localparam logic [7:0] CH_UC_X  = 8'd88;
  localparam logic [7:0] CH_LC_A  = 8'd97;
  localparam logic [7:0] CH_LC_F  = 8'd102;
  localparam logic [7:0] CH_LC_X  = 8'd120;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Classification of one character.
  typedef struct packed {
    logic       is_nul;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

@@ src/ascii_integer_parser_core.sv @@
// Top level of the ASCII integer parser: input register, parse state and
// result register. Uses aip_pkg, aip_class and assert_macros.svh.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_ready, in_char_code[7:0]   | in
//   result  | out_valid, out_ready, out_status,       | out
//           | out_value[63:0]                         |
//
// One character word is taken per cycle unless a zero byte is held; the
// parse step is one multiply by ten or sixteen (shift and add) between the
// input register and the state. A result is registered and offered from
// the edge at which its zero byte leaves the input register.
// Reset (synchronous, active low) empties both registers and returns the
// parse state to the leading white space phase; no clearing pass is needed.
// Only a zero byte waits for a full result register; other words pass on.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ascii_integer_parser_core
  import aip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [63:0]      out_value
);

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_START = 3'd1,
    PH_ZERO  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4,
    PH_TRAIL = 3'd5,
    PH_BAD   = 3'd6
  } phase_t;

  // Input register.
  logic        in_vld_r;
  logic [7:0]  in_char_r;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        nodig_r, nodig_nxt;

  // Result register.
  logic        out_vld_r;
  logic        out_status_r, out_status_nxt;
  logic [63:0] out_value_r, out_value_nxt;

  char_class_t cls;
  logic        consume;
  logic        finish;
  logic [63:0] acc_dec;
  logic [63:0] acc_hex;
  phase_t      ph_after;

  aip_class u_class (
    .char_code (in_char_r),
    .cls       (cls)
  );

  // A zero byte may leave only when the result register is free or being read.
  assign consume  = in_vld_r && (!cls.is_nul || !out_vld_r || out_ready);
  assign finish   = consume && cls.is_nul;
  assign in_ready = !in_vld_r || consume;

  // Accumulator steps: times ten and times sixteen as shifts and adds.
  assign acc_dec  = (acc_r << 3) + (acc_r << 1) + {60'd0, cls.digit};
  assign acc_hex  = {acc_r[59:0], cls.digit};
  assign ph_after = cls.is_space ? PH_TRAIL : PH_BAD;

  // Next parse state for one character word.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    nodig_nxt = nodig_r;
    if (finish) begin
      phase_nxt = PH_LEAD;
      acc_nxt   = 64'd0;
      neg_nxt   = 1'b0;
      nodig_nxt = 1'b1;
    end else if (consume) begin
      unique case (phase_r)
        PH_LEAD, PH_START: begin
          if ((phase_r == PH_LEAD) && cls.is_space) begin
            phase_nxt = PH_LEAD;
          end else if ((phase_r == PH_LEAD) && cls.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_START;
          end else if ((phase_r == PH_LEAD) && cls.is_plus) begin
            phase_nxt = PH_START;
          end else if (cls.is_zero) begin
            acc_nxt   = 64'd0;
            nodig_nxt = 1'b0;
            phase_nxt = PH_ZERO;
          end else if (cls.is_dec) begin
            acc_nxt   = acc_dec;
            nodig_nxt = 1'b0;
            phase_nxt = PH_DEC;
          end else begin
            phase_nxt = ph_after;
          end
        end
        PH_ZERO: begin
          if (cls.is_x) begin
            nodig_nxt = 1'b1;
            acc_nxt   = 64'd0;
            phase_nxt = PH_HEX;
          end else if (cls.is_dec) begin
            acc_nxt   = acc_dec;
            nodig_nxt = 1'b0;
            phase_nxt = PH_DEC;
          end else begin
            phase_nxt = ph_after;
          end
        end
        PH_DEC: begin
          if (cls.is_dec) begin
            acc_nxt   = acc_dec;
            nodig_nxt = 1'b0;
          end else begin
            phase_nxt = ph_after;
          end
        end
        PH_HEX: begin
          if (cls.is_hex) begin
            acc_nxt   = acc_hex;
            nodig_nxt = 1'b0;
          end else begin
            phase_nxt = ph_after;
          end
        end
        PH_TRAIL: begin
          if (!cls.is_space) begin
            phase_nxt = PH_BAD;
          end
        end
        default: begin
          phase_nxt = PH_BAD;
        end
      endcase
    end
  end

  // Result word formed from the state that the zero byte finds.
  always_comb begin
    if (nodig_r || (phase_r == PH_BAD)) begin
      out_status_nxt = STATUS_BAD;
      out_value_nxt  = 64'd0;
    end else begin
      out_status_nxt = STATUS_OK;
      out_value_nxt  = neg_r ? (64'd0 - acc_r) : acc_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_LEAD;
      acc_r     <= 64'd0;
      neg_r     <= 1'b0;
      nodig_r   <= 1'b1;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      nodig_r <= nodig_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_code;
    end
    if (finish) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  // A malformed result always carries a zero value.
  `AIP_NEVER(a_bad_is_zero, clk, rst_n,
    out_vld_r && (out_status_r == STATUS_BAD) && (out_value_r != 64'd0))
  // A zero byte leaves the parse state at its reset values.
  `AIP_ASSERT(a_finish_resets, clk, rst_n,
    finish |=> ((phase_r == PH_LEAD) && (acc_r == 64'd0) && !neg_r && nodig_r))
  // A held word in the input register is neither lost nor altered.
  `AIP_ASSERT(a_hold_input, clk, rst_n,
    (in_vld_r && !consume) |=> (in_vld_r && $stable(in_char_r)))
  // A pending result is never overwritten by the next one.
  `AIP_NEVER(a_no_overwrite, clk, rst_n, finish && out_vld_r && !out_ready)

endmodule

`default_nettype wire

@@ src/aip_class.sv @@
// Character classifier of the ASCII integer parser: white space, signs,
// decimal and hexadecimal digits with their values. Uses aip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aip_class
  import aip_pkg::*;
(
  input  wire logic [7:0]  char_code,
  output char_class_t      cls
);

  logic dec;
  logic lc_hex;
  logic uc_hex;

  // Digit ranges.
  assign dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign lc_hex = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
  assign uc_hex = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);

  // Flags and digit value. Letters a..f and A..F share their low three bits,
  // so the value is nine plus those bits.
  always_comb begin
    cls.is_nul   = (char_code == CH_NUL);
    cls.is_space = (char_code == CH_SPACE) ||
                   ((char_code >= CH_TAB) && (char_code <= CH_CR));
    cls.is_minus = (char_code == CH_MINUS);
    cls.is_plus  = (char_code == CH_PLUS);
    cls.is_zero  = (char_code == CH_ZERO);
    cls.is_x     = (char_code == CH_LC_X) || (char_code == CH_UC_X);
    cls.is_dec   = dec;
    cls.is_hex   = dec || lc_hex || uc_hex;
    if (dec) begin
      cls.digit = char_code[3:0];
    end else begin
      cls.digit = 4'd9 + {1'b0, char_code[2:0]};
    end
  end

endmodule

`default_nettype wire

@@ test/ascii_integer_parser_core_test.sv @@
// Self-checking bench for ascii_integer_parser_core: drives character words, predicts
// each numeral's status and value, and compares them with the result words.
// Depends on aip_pkg and the RTL of ascii_integer_parser_core only.
`timescale 1ns / 1ps

module ascii_integer_parser_core_test;
  import aip_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_CHARS = 275;

  typedef enum logic [2:0] {
    LEAD_SPACE, AFTER_SIGN, SEEN_ZERO, DEC_DIGITS, HEX_DIGITS, TRAIL_SPACE, MALFORMED
  } parse_phase_t;

  typedef struct packed {
    logic        status;
    logic [63:0] value;
  } numeral_t;

  // Tracks the parse of the character stream and the numerals still owed.
  class numeral_scoreboard;
    parse_phase_t phase;
    logic [63:0]  acc;
    bit           negative;
    bit           no_digits;
    numeral_t     owed_numerals[$];
    int           errors;
    int           chars_taken;
    int           numerals_checked;
    int           malformed_seen;

    function void clear_state();
      phase     = LEAD_SPACE;
      acc       = 64'd0;
      negative  = 1'b0;
      no_digits = 1'b1;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // A decimal digit extends the number; anything else closes the digits.
    function void decimal_char(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc       = acc * 64'd10 + 64'(c - CH_ZERO);
        no_digits = 1'b0;
        phase     = DEC_DIGITS;
      end else begin
        phase = is_space(c) ? TRAIL_SPACE : MALFORMED;
      end
    endfunction

    // The first character after the optional sign may open a hex prefix.
    function void first_char(logic [7:0] c);
      if (c == CH_ZERO) begin
        acc       = 64'd0;
        no_digits = 1'b0;
        phase     = SEEN_ZERO;
      end else begin
        decimal_char(c);
      end
    endfunction

    // Notes one accepted character word; a zero byte closes the numeral.
    function void take_char(logic [7:0] c);
      numeral_t owed;
      chars_taken++;
      if (c == CH_NUL) begin
        if (no_digits || phase == MALFORMED) begin
          owed = '{status: STATUS_BAD, value: 64'd0};
          malformed_seen++;
        end else begin
          owed = '{status: STATUS_OK, value: negative ? 64'd0 - acc : acc};
        end
        owed_numerals.push_back(owed);
        clear_state();
        return;
      end
      case (phase)
        LEAD_SPACE: begin
          if (is_space(c)) begin
          end else if (c == CH_MINUS) begin
            negative = 1'b1;
            phase    = AFTER_SIGN;
          end else if (c == CH_PLUS) begin
            phase = AFTER_SIGN;
          end else begin
            first_char(c);
          end
        end
        AFTER_SIGN: first_char(c);
        SEEN_ZERO: begin
          if (c == CH_LC_X || c == CH_UC_X) begin
            no_digits = 1'b1;
            acc       = 64'd0;
            phase     = HEX_DIGITS;
          end else begin
            decimal_char(c);
          end
        end
        DEC_DIGITS: decimal_char(c);
        HEX_DIGITS: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            acc       = {acc[59:0], 4'(c - CH_ZERO)};
            no_digits = 1'b0;
          end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            acc       = {acc[59:0], 4'(c - CH_LC_A + 8'd10)};
            no_digits = 1'b0;
          end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            acc       = {acc[59:0], 4'(c - CH_UC_A + 8'd10)};
            no_digits = 1'b0;
          end else begin
            phase = is_space(c) ? TRAIL_SPACE : MALFORMED;
          end
        end
        TRAIL_SPACE: if (!is_space(c)) phase = MALFORMED;
        default: phase = MALFORMED;
      endcase
    endfunction

    function void report(string what, numeral_t owed, logic st, logic [63:0] val);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected status %0d value 0x%016h, got status %0d value 0x%016h",
                 what, owed.status, owed.value, st, val);
    endfunction

    // Compares one result word with the oldest numeral owed.
    function void check_numeral(logic st, logic [63:0] val);
      numeral_t owed;
      numerals_checked++;
      if (owed_numerals.size() == 0) begin
        report("result word with no numeral pending", '0, st, val);
        return;
      end
      owed = owed_numerals.pop_front();
      if (owed.status !== st || owed.value !== val) report("numeral", owed, st, val);
    endfunction

    function int pending();
      return owed_numerals.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [63:0] out_value;

  numeral_scoreboard board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  ascii_integer_parser_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_code(in_char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_value   (out_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check accepted words, then choose whether to stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_numeral(out_status, out_value);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("ascii_integer_parser_core verification failed");
      $finish;
    end
  end

  function automatic int idle_gap(int pct);
    int n;
    n = 0;
    while (n < 60 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic logic [7:0] space_char();
    int pick;
    pick = $urandom_range(5);
    return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  // Offers one character word and waits for it to be taken.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    board.take_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // Holds the sender off until every owed numeral has come back.
  task automatic wait_for_numerals();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed numerals with random content, some corrupted, some noise.
  task automatic send_random_numeral();
    logic [7:0] text[$];
    int kind;
    int n;
    int v;
    kind = $urandom_range(99);
    repeat ($urandom_range(2)) text.push_back(space_char());
    if (kind < 85) begin
      case ($urandom_range(2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
      if ($urandom_range(1)) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
        repeat (n) begin
          v = $urandom_range(15);
          if (v < 10) text.push_back(CH_ZERO + 8'(v));
          else text.push_back(($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(v - 10));
        end
      end else begin
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      repeat ($urandom_range(2)) text.push_back(space_char());
      // Corrupt some of them with a stray byte anywhere in the string.
      if (kind >= 70) text.insert($urandom_range(text.size()), 8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(6)) text.push_back(8'($urandom_range(1, 255)));
    end
    text.push_back(CH_NUL);
    foreach (text[i]) send_char(text[i]);
  endtask

  initial begin
    int target;
    int idle_set[4];
    int stall_set[4];
    board = new();
    board.clear_state();
    idle_set  = '{0, 78, 0, 23};
    stall_set = '{0, 0, 78, 23};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed numerals: signs, hex prefix in both cases, empty and stray cases.
    send_text(" -0xaF");
    send_text("+");
    send_text("\377");
    send_text("\0150X");
    send_text("07a");
    send_text("9\t");
    send_text("");
    wait_for_numerals();

    // Random numerals under each idling regime, drained between regimes.
    target = board.chars_taken;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      target += RANDOM_CHARS;
      while (board.chars_taken < target) send_random_numeral();
      wait_for_numerals();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d character words and %0d numerals, %0d of them malformed,",
             board.chars_taken, board.numerals_checked, board.malformed_seen);
    $display("with sender gaps and receiver stalls in four regimes; %0d mismatches.",
             board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ascii_integer_parser_core verification clean");
    end else begin
      $display("ascii_integer_parser_core verification failed");
    end
    $finish;
  end

endmodule
